// ===== rtl/fss_pkg.sv =====
// Shared types and constants for the first-occurrence substring search unit.
// No dependencies.
package fss_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int OFFSET_BITS = 32;
  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int SYM_W = 8;
  localparam int SYM_DEPTH = 1 << SYM_W;

  typedef enum logic [2:0] {
    ACT_CLEAR  = 3'd0,
    ACT_APPEND = 3'd1,
    ACT_START  = 3'd2,
    ACT_BYTE   = 3'd3,
    ACT_END    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_MATCH     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  byte_value;
    logic [31:0] start_offset;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] position;
  } out_word_t;

endpackage

// ===== rtl/fss_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read (read-first).
// No dependencies.
module fss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/first_occurrence_substring_search_unit.sv =====
// Top level of the first-occurrence substring search unit (shift-and matcher).
// Depends on fss_pkg and fss_ram.
//
// channel | signals                 | word
// --------+-------------------------+------------------------------------
// request | req_valid, req_ready    | req  (action, byte_value, start_offset)
// result  | rsp_valid, rsp_ready    | rsp  (status, position)
//
// One word per cycle unless a stalled result or a table clear holds req_ready low;
// rsp_valid rises as the stage fires with a result. A per-byte-value mask table
// (256 x MAX_PATTERN bits) lives in one RAM with a registered read; back-to-back
// appends forward the last write. Reset starts a 256-entry table clearing pass with
// req_ready low; a pattern clear holds req_ready low in the stage, then for the pass.
// A stalled result holds the stage, so at most two words are in flight.
module first_occurrence_substring_search_unit
  import fss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  in_word_t  req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_word_t rsp
);

  logic                   s1_valid;
  in_word_t               s1;
  logic                   s1_fire;

  logic                   clr_active;
  logic [SYM_W-1:0]       clr_addr;

  logic [CNT_W-1:0]       count, count_next;
  logic                   overflow, overflow_next;
  logic                   done, done_next;
  logic [MAX_PATTERN-1:0] dvec, dvec_next;
  logic [OFFSET_BITS-1:0] seen, seen_next;
  logic [OFFSET_BITS-1:0] base, base_next;

  logic                   fwd_valid;
  logic [SYM_W-1:0]       fwd_addr;
  logic [MAX_PATTERN-1:0] fwd_data;

  logic                   ram_we;
  logic [SYM_W-1:0]       ram_waddr;
  logic [MAX_PATTERN-1:0] ram_wdata;
  logic [MAX_PATTERN-1:0] ram_rdata;
  logic [MAX_PATTERN-1:0] mask;

  logic                   app_we;
  logic [MAX_PATTERN-1:0] app_data;
  logic                   res_valid;
  out_word_t              res;
  logic                   start_clear;
  logic [OFFSET_BITS-1:0] pos_full;

  assign s1_fire   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !clr_active && !(s1_valid && s1.action == ACT_CLEAR) &&
                     (!s1_valid || s1_fire);

  assign mask = (fwd_valid && fwd_addr == s1.byte_value) ? fwd_data : ram_rdata;

  assign ram_we    = clr_active || (s1_fire && app_we);
  assign ram_waddr = clr_active ? clr_addr : s1.byte_value;
  assign ram_wdata = clr_active ? '0 : app_data;

  fss_ram #(
    .WIDTH(MAX_PATTERN),
    .DEPTH(SYM_DEPTH)
  ) u_mask_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (req_valid && req_ready),
    .raddr(req.byte_value),
    .rdata(ram_rdata)
  );

  assign pos_full = base + seen_next - OFFSET_BITS'(count);

  always_comb begin
    count_next    = count;
    overflow_next = overflow;
    done_next     = done;
    dvec_next     = dvec;
    seen_next     = seen;
    base_next     = base;
    app_we        = 1'b0;
    app_data      = mask | (MAX_PATTERN'(1) << count[IDX_W-1:0]);
    res_valid     = 1'b0;
    res           = '0;
    start_clear   = 1'b0;
    unique case (s1.action)
      ACT_CLEAR: begin
        count_next    = '0;
        overflow_next = 1'b0;
        done_next     = 1'b1;
        start_clear   = 1'b1;
      end
      ACT_APPEND: begin
        done_next = 1'b1;
        if (count < CNT_W'(MAX_PATTERN)) begin
          app_we     = 1'b1;
          count_next = count + 1'b1;
        end else begin
          overflow_next = 1'b1;
          res_valid     = 1'b1;
          res.status    = ST_OVERFLOW;
        end
      end
      ACT_START: begin
        base_next = s1.start_offset[OFFSET_BITS-1:0];
        seen_next = '0;
        dvec_next = '0;
        done_next = 1'b1;
        if (overflow) begin
          res_valid  = 1'b1;
          res.status = ST_OVERFLOW;
        end else if (count == '0) begin
          res_valid    = 1'b1;
          res.status   = ST_MATCH;
          res.position = 32'(s1.start_offset[OFFSET_BITS-1:0]);
        end else begin
          done_next = 1'b0;
        end
      end
      ACT_BYTE: begin
        if (!done) begin
          dvec_next = ((dvec << 1) | MAX_PATTERN'(1)) & mask;
          seen_next = (&seen) ? seen : seen + 1'b1;
          if (dvec_next[IDX_W'(count - 1'b1)]) begin
            done_next    = 1'b1;
            res_valid    = 1'b1;
            res.status   = ST_MATCH;
            res.position = 32'(pos_full);
          end
        end
      end
      ACT_END: begin
        if (!done) begin
          done_next  = 1'b1;
          res_valid  = 1'b1;
          res.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s1         <= '0;
      clr_active <= 1'b1;
      clr_addr   <= '0;
      count      <= '0;
      overflow   <= 1'b0;
      done       <= 1'b1;
      dvec       <= '0;
      seen       <= '0;
      base       <= '0;
      fwd_valid  <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        s1_valid <= 1'b1;
        s1       <= req;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (clr_active) begin
        clr_addr <= clr_addr + 1'b1;
        if (&clr_addr) begin
          clr_active <= 1'b0;
        end
        fwd_valid <= 1'b0;
      end
      if (s1_fire) begin
        count    <= count_next;
        overflow <= overflow_next;
        done     <= done_next;
        dvec     <= dvec_next;
        seen     <= seen_next;
        base     <= base_next;
        if (app_we) begin
          fwd_valid <= 1'b1;
          fwd_addr  <= s1.byte_value;
          fwd_data  <= app_data;
        end
        if (start_clear) begin
          clr_active <= 1'b1;
          clr_addr   <= '0;
          fwd_valid  <= 1'b0;
        end
      end
      if (s1_fire && res_valid) begin
        rsp_valid <= 1'b1;
        rsp       <= res;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== tb/sv/tb_first_occurrence_substring_search_unit.sv =====
`timescale 1ns / 1ps
// Testbench for first_occurrence_substring_search_unit: random and directed
// request words, an in-bench search predictor and an in-order result check.
// Depends on fss_pkg and the RTL top level.
module tb_first_occurrence_substring_search_unit;
  import fss_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  in_word_t  req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  out_word_t rsp;

  first_occurrence_substring_search_unit dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always #5 clk = ~clk;

  in_word_t  pending_words[$];
  out_word_t expected_results[$];
  int        errors = 0;
  int        cycles = 0;
  int        hold_off = 0;
  bit        pause_send = 0;
  bit        req_taken = 0;

  // predictor state
  logic [7:0]  pat[MAX_PATTERN];
  logic [7:0]  win[MAX_PATTERN];
  int          pat_len = 0;
  bit          ovf = 0;
  logic [31:0] seen = 0;
  logic [31:0] base = 0;
  bit          idle = 1;

  task automatic push_result(input status_t s, input logic [31:0] p);
    out_word_t r;
    r.status = s;
    r.position = p;
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic predict_search(input in_word_t w);
    bit hit;
    case (w.action)
      ACT_CLEAR: begin
        pat_len = 0;
        ovf = 0;
        idle = 1;
      end
      ACT_APPEND: begin
        idle = 1;
        if (pat_len < MAX_PATTERN) begin
          pat[pat_len] = w.byte_value;
          pat_len++;
        end else begin
          ovf = 1;
          push_result(ST_OVERFLOW, '0);
        end
      end
      ACT_START: begin
        base = w.start_offset;
        seen = 0;
        foreach (win[i]) win[i] = '0;
        idle = 1;
        if (ovf) push_result(ST_OVERFLOW, '0);
        else if (pat_len == 0) push_result(ST_MATCH, base);
        else idle = 0;
      end
      ACT_BYTE: begin
        if (!idle) begin
          for (int i = MAX_PATTERN - 1; i > 0; i--) win[i] = win[i-1];
          win[0] = w.byte_value;
          if (seen != 32'hffff_ffff) seen++;
          hit = (seen >= pat_len);
          for (int j = 0; j < pat_len; j++)
            if (win[pat_len-1-j] != pat[j]) hit = 0;
          if (hit) begin
            idle = 1;
            push_result(ST_MATCH, base + seen - pat_len);
          end
        end
      end
      ACT_END: begin
        if (!idle) begin
          idle = 1;
          push_result(ST_NOT_FOUND, '0);
        end
      end
      default: ;
    endcase
  endtask

  // driver: bursts and gaps, changes on falling edge
  int burst = 0;
  int gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!req_valid || req_taken) begin
        if (gap > 0) begin
          gap--;
          req_valid <= 1'b0;
        end else if (pending_words.size() > 0 && !pause_send) begin
          req <= pending_words.pop_front();
          req_valid <= 1'b1;
          if (burst == 0) begin
            burst = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) gap = $urandom_range(0, 6);
          end else begin
            burst--;
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: own stall pattern and one long hold-off
  always @(negedge clk) begin
    if (!rst) begin
      if (cycles == 6000) hold_off = 800;
      if (hold_off > 0) begin
        hold_off--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ((cycles / 300) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      cycles <= cycles + 1;
      req_taken <= req_valid && req_ready;
      if (req_valid && req_ready) predict_search(req);
      if (rsp_valid && rsp_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: expected no word, actual status=%0d position=%h", $time,
                   rsp.status, rsp.position);
          errors++;
        end else begin
          out_word_t e;
          e = expected_results.pop_front();
          if (rsp.status !== e.status)
            $display("%0t: status expected %0d actual %0d", $time, e.status, rsp.status);
          if (rsp.position !== e.position)
            $display("%0t: position expected %h actual %h", $time, e.position,
                     rsp.position);
          if (rsp.status !== e.status || rsp.position !== e.position) errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("[first_occurrence_substring_search_unit] ERROR");
      $finish;
    end
  end

  function automatic in_word_t mk(input action_t a, input logic [7:0] b,
                                  input logic [31:0] o);
    in_word_t w;
    w.action = a;
    w.byte_value = b;
    w.start_offset = o;
    return w;
  endfunction

  task automatic add(input action_t a, input logic [7:0] b, input logic [31:0] o);
    pending_words.insert(pending_words.size(), mk(a, b, o));
  endtask

  task automatic add_noise();
    in_word_t w;
    w.action = 3'($urandom());
    w.byte_value = 8'($urandom());
    w.start_offset = $urandom();
    pending_words.insert(pending_words.size(), w);
  endtask

  // well-formed search: new pattern, start, stream that may hold a planted copy
  task automatic add_search(output int words);
    logic [7:0] p[$];
    logic [7:0] v;
    int len, n, at, alpha, size_before;
    size_before = pending_words.size();
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 5);
    alpha = $urandom_range(0, 3) == 0 ? 255 : $urandom_range(1, 3);
    add(ACT_CLEAR, 8'($urandom()), $urandom());
    for (int i = 0; i < len; i++) begin
      v = 8'($urandom_range(0, alpha));
      p.insert(p.size(), v);
      add(ACT_APPEND, v, $urandom());
    end
    if ($urandom_range(0, 9) == 0) add(ACT_APPEND, 8'($urandom()), $urandom());
    add(ACT_START, 8'($urandom()),
        $urandom_range(0, 4) == 0 ? 32'hffff_ffff - $urandom_range(0, 8) : $urandom());
    n = $urandom_range(0, 12);
    at = $urandom_range(0, n);
    for (int i = 0; i < n; i++) begin
      if (i == at && $urandom_range(0, 1))
        foreach (p[k]) add(ACT_BYTE, p[k], $urandom());
      add(ACT_BYTE, 8'($urandom_range(0, alpha)), $urandom());
    end
    if ($urandom_range(0, 5) != 0) add(ACT_END, 8'($urandom()), $urandom());
    words = pending_words.size() - size_before;
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || req_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic wait_results();
    while (req_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int w, total;
    bit paused;
    paused = 0;
    foreach (pat[i]) pat[i] = '0;
    foreach (win[i]) win[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed
    add(ACT_START, 8'h00, 32'h0000_0000);
    add(ACT_START, 8'hff, 32'hffff_ffff);
    add(ACT_BYTE, 8'h12, '0);
    add(ACT_END, 8'h00, '0);
    add(ACT_APPEND, 8'hff, '0);
    add(ACT_APPEND, 8'h00, '0);
    add(ACT_START, 8'h00, 32'hffff_fffe);
    add(ACT_BYTE, 8'hff, '0);
    add(ACT_BYTE, 8'hff, '0);
    add(ACT_BYTE, 8'h00, '0);
    add(ACT_START, 8'h00, 32'h10);
    add(ACT_BYTE, 8'h01, '0);
    add(ACT_END, 8'h00, '0);
    add(ACT_START, 8'h00, 32'h20);
    add(ACT_APPEND, 8'h55, '0);
    add(ACT_END, 8'h00, '0);
    pending_words.insert(pending_words.size(), in_word_t'({3'd5, 8'hff, 32'hffff_ffff}));
    pending_words.insert(pending_words.size(), in_word_t'({3'd7, 8'h00, 32'h0}));
    wait_drained();
    add(ACT_CLEAR, 8'h00, '0);
    for (int i = 0; i < MAX_PATTERN + 1; i++) add(ACT_APPEND, i[7:0], '0);
    add(ACT_START, 8'h00, 32'h5);
    add(ACT_CLEAR, 8'h00, '0);
    add(ACT_START, 8'h00, 32'h7);
    wait_drained();

    total = 0;
    while (total < 1750) begin
      if ($urandom_range(0, 9) == 0) begin
        add_noise();
        total++;
      end else begin
        add_search(w);
        total += w;
      end
      if (!paused && total > 900) begin
        paused = 1;
        pause_send = 1;
        wait_results();
        pause_send = 0;
      end
      while (pending_words.size() > 40) @(posedge clk);
    end
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[first_occurrence_substring_search_unit] OK");
    end else begin
      $display("[first_occurrence_substring_search_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fss_pkg.sv
rtl/fss_ram.sv
rtl/first_occurrence_substring_search_unit.sv
tb/sv/tb_first_occurrence_substring_search_unit.sv
